[design/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, widths and coil pattern tables for the stepper phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 8;
  localparam int PHASE_W  = 2;
  localparam int COIL_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_OFF      = 2'd0,
    CFG_FOLLOWER_MODE  = 2'd1,
    CFG_FULL_STEP_MODE = 2'd2,
    CFG_FORWARD_DIR    = 2'd3
  } cfg_idx_t;

  // operating mode bits handed to the step logic
  typedef struct packed {
    logic drive_off;
    logic follower_mode;
    logic full_step_mode;
    logic forward_dir;
  } cfg_t;

  // coil patterns
  localparam logic [COIL_W-1:0] COIL_OFF = 4'h0;
  localparam logic [COIL_W-1:0] FULL_P0  = 4'hC;
  localparam logic [COIL_W-1:0] FULL_P1  = 4'h6;
  localparam logic [COIL_W-1:0] FULL_P2  = 4'h3;
  localparam logic [COIL_W-1:0] FULL_P3  = 4'h9;
  localparam logic [COIL_W-1:0] WAVE_P0  = 4'h8;
  localparam logic [COIL_W-1:0] WAVE_P1  = 4'h4;
  localparam logic [COIL_W-1:0] WAVE_P2  = 4'h2;
  localparam logic [COIL_W-1:0] WAVE_P3  = 4'h1;

  // table lookup: forward tables run P0..P3, reverse tables run P3..P0
  function automatic logic [COIL_W-1:0] coil_lookup(
    input logic               full,
    input logic               fwd,
    input logic [PHASE_W-1:0] phase
  );
    logic [PHASE_W-1:0] idx;
    logic [COIL_W-1:0]  pat;
    idx = fwd ? phase : ~phase;
    case (idx)
      2'd0: pat = full ? FULL_P0 : WAVE_P0;
      2'd1: pat = full ? FULL_P1 : WAVE_P1;
      2'd2: pat = full ? FULL_P2 : WAVE_P2;
      2'd3: pat = full ? FULL_P3 : WAVE_P3;
      default: pat = COIL_OFF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

[design/sps_input_stage.sv]
// ----------------------------------------------------------------------------
// sps_input_stage
// Input register: holds one sample transaction until the step logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_input_stage (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [sps_pkg::SAMPLE_W-1:0] in_pot_sample,
  output      logic                         s1_valid,
  input  wire logic                         s1_take,
  output      logic [sps_pkg::SAMPLE_W-1:0] s1_sample
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic [sps_pkg::SAMPLE_W-1:0] sample_r;

  // free when empty or when the held item moves on this cycle
  assign in_ready = !valid_r || s1_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_pot_sample;
    end
  end

  assign s1_valid  = valid_r;
  assign s1_sample = sample_r;

endmodule

`default_nettype wire

[design/sps_step_core.sv]
// ----------------------------------------------------------------------------
// sps_step_core
// Position and phase state with the per-tick step decision and table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_step_core #(
  parameter int STEPS        = 200,
  parameter int SAMPLE_RANGE = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sps_pkg::cfg_t                cfg,
  input  wire logic                         fire,
  input  wire logic [sps_pkg::SAMPLE_W-1:0] sample,
  output      logic [sps_pkg::COIL_W-1:0]   coil,
  output      logic [sps_pkg::POS_W-1:0]    pos_next
);

  // wide enough for (position + 1) * SAMPLE_RANGE and sample * STEPS
  localparam int PROD_W =
    $clog2((SAMPLE_RANGE + (1 << sps_pkg::SAMPLE_W)) * (1 << sps_pkg::POS_W) + 1);

  localparam logic [sps_pkg::POS_W-1:0] STEPS_V  = sps_pkg::POS_W'(STEPS);
  localparam logic [sps_pkg::POS_W-1:0] STEPS_M1 = sps_pkg::POS_W'(STEPS - 1);

  logic [sps_pkg::POS_W-1:0]   pos_r;
  logic [sps_pkg::PHASE_W-1:0] phase_r;
  logic [sps_pkg::PHASE_W-1:0] phase_nxt;

  logic [PROD_W-1:0]           scaled;
  logic [PROD_W-1:0]           up_thr;
  logic [PROD_W-1:0]           dn_thr;
  logic [sps_pkg::POS_W:0]     pos_inc;
  logic                        step_en;

  // compare sample*STEPS against position bounds instead of dividing
  assign scaled  = PROD_W'(sample) * PROD_W'(STEPS);
  assign dn_thr  = PROD_W'(pos_r) * PROD_W'(SAMPLE_RANGE);
  assign up_thr  = dn_thr + PROD_W'(SAMPLE_RANGE);
  assign pos_inc = {1'b0, pos_r} + 1'b1;

  // step decision, next position and coil pattern
  always_comb begin
    pos_next = pos_r;
    coil     = sps_pkg::COIL_OFF;
    step_en  = 1'b0;
    if (cfg.drive_off) begin
      pos_next = pos_r;
    end else if (cfg.follower_mode) begin
      // target saturates at the last step, so a position past it walks down
      if (pos_r < STEPS_M1 && scaled >= up_thr) begin
        pos_next = pos_inc[sps_pkg::POS_W-1:0];
        coil     = sps_pkg::coil_lookup(1'b1, 1'b1, phase_r);
        step_en  = 1'b1;
      end else if (scaled < dn_thr || pos_r > STEPS_M1) begin
        pos_next = pos_r - 1'b1;
        coil     = sps_pkg::coil_lookup(1'b1, 1'b0, phase_r);
        step_en  = 1'b1;
      end
    end else begin
      step_en = 1'b1;
      coil    = sps_pkg::coil_lookup(cfg.full_step_mode, cfg.forward_dir, phase_r);
      if (cfg.forward_dir) begin
        if (pos_inc >= {1'b0, STEPS_V}) begin
          pos_next = '0;
        end else begin
          pos_next = pos_inc[sps_pkg::POS_W-1:0];
        end
      end else begin
        if (pos_r == '0 || pos_r > STEPS_V) begin
          pos_next = STEPS_M1;
        end else begin
          pos_next = pos_r - 1'b1;
        end
      end
    end
  end

  assign phase_nxt = step_en ? phase_r + 1'b1 : phase_r;

  // position and phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= '0;
    end else if (fire) begin
      pos_r   <= pos_next;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

[design/stepper_phase_sequencer.sv]
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Full-step / wave-drive stepper sequencer with potentiometer follower mode.
//
// Usage: each input transaction (in_valid/in_ready, in_pot_sample) is one
// step tick and yields exactly one result transaction (out_valid/out_ready)
// with the coil pattern and the position after that tick.
// Flow: an accepted tick is held in the input register, then the step
// decision and table lookup feed the result register, which raises out_valid.
// Throughput is one transaction per cycle while out_ready stays high; the
// input register and the result register each hold one item, so a new
// tick is accepted while a finished result still waits on the output.
// When out_ready is low the result register holds, the input register fills,
// and in_ready drops until the receiver takes the pending result.
// Reset (rst_n low, synchronous) empties both registers, sets position and
// phase to zero, and loads drive_off=1, follower_mode=0, full_step_mode=0,
// forward_dir=1. The cfg_ port writes one mode bit per cfg_we cycle. The user
// must use it only while no transaction is in flight; nothing here enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer #(
  parameter int STEPS        = 200,
  parameter int SAMPLE_RANGE = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [sps_pkg::SAMPLE_W-1:0]   in_pot_sample,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [sps_pkg::COIL_W-1:0]     out_coil_pattern,
  output      logic [sps_pkg::POS_W-1:0]      out_position,
  input  wire logic                           cfg_we,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sps_pkg::cfg_t                cfg_r;
  logic                         s1_valid;
  logic                         s1_take;
  logic [sps_pkg::SAMPLE_W-1:0] s1_sample;
  logic [sps_pkg::COIL_W-1:0]   coil;
  logic [sps_pkg::POS_W-1:0]    pos_next;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [sps_pkg::COIL_W-1:0]   coil_r;
  logic [sps_pkg::POS_W-1:0]    pos_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_off      <= 1'b1;
      cfg_r.follower_mode  <= 1'b0;
      cfg_r.full_step_mode <= 1'b0;
      cfg_r.forward_dir    <= 1'b1;
    end else if (cfg_we) begin
      case (sps_pkg::cfg_idx_t'(cfg_index))
        sps_pkg::CFG_DRIVE_OFF:      cfg_r.drive_off      <= cfg_wdata[0];
        sps_pkg::CFG_FOLLOWER_MODE:  cfg_r.follower_mode  <= cfg_wdata[0];
        sps_pkg::CFG_FULL_STEP_MODE: cfg_r.full_step_mode <= cfg_wdata[0];
        sps_pkg::CFG_FORWARD_DIR:    cfg_r.forward_dir    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  sps_input_stage u_input (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pot_sample (in_pot_sample),
    .s1_valid      (s1_valid),
    .s1_take       (s1_take),
    .s1_sample     (s1_sample)
  );

  // held item moves into the result register when that register is empty or drains
  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  // step logic and state
  sps_step_core #(
    .STEPS        (STEPS),
    .SAMPLE_RANGE (SAMPLE_RANGE)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fire     (s1_take),
    .sample   (s1_sample),
    .coil     (coil),
    .pos_next (pos_next)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || out_ready) begin
      out_valid_nxt = s1_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      coil_r <= coil;
      pos_r  <= pos_next;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coil_pattern = coil_r;
  assign out_position     = pos_r;

endmodule

`default_nettype wire

[tb/sps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_checker
// Watches the tick, result and mode write ports of the stepper phase
// sequencer, predicts each coil pattern and position, and compares them in
// order against the results the block hands out.
// ----------------------------------------------------------------------------
module sps_checker #(
  parameter int STEPS        = 200,
  parameter int SAMPLE_RANGE = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [sps_pkg::SAMPLE_W-1:0]   in_pot_sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [sps_pkg::COIL_W-1:0]     out_coil_pattern,
  input  logic [sps_pkg::POS_W-1:0]      out_position,
  input  logic                           cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           run_done,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  // expected result of one step tick
  typedef struct packed {
    logic [sps_pkg::COIL_W-1:0] coils;
    logic [sps_pkg::POS_W-1:0]  pos;
  } tick_result_t;

  // coil sequences, entry 0 in the low nibble
  localparam logic [15:0] FWD_FULL = {sps_pkg::FULL_P3, sps_pkg::FULL_P2,
                                      sps_pkg::FULL_P1, sps_pkg::FULL_P0};
  localparam logic [15:0] REV_FULL = {sps_pkg::FULL_P0, sps_pkg::FULL_P1,
                                      sps_pkg::FULL_P2, sps_pkg::FULL_P3};
  localparam logic [15:0] FWD_WAVE = {sps_pkg::WAVE_P3, sps_pkg::WAVE_P2,
                                      sps_pkg::WAVE_P1, sps_pkg::WAVE_P0};
  localparam logic [15:0] REV_WAVE = {sps_pkg::WAVE_P0, sps_pkg::WAVE_P1,
                                      sps_pkg::WAVE_P2, sps_pkg::WAVE_P3};

  sps_pkg::cfg_t               mode;
  logic [sps_pkg::POS_W-1:0]   shaft_pos;
  logic [sps_pkg::PHASE_W-1:0] phase_idx;
  tick_result_t                expected_q[$];
  tick_result_t                want;
  bit                          leftovers_checked;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t ns] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // take the next entry of a coil sequence and advance the phase
  function automatic logic [sps_pkg::COIL_W-1:0] next_coils(input logic [15:0] seq);
    logic [sps_pkg::COIL_W-1:0] pat;
    pat       = seq[phase_idx*sps_pkg::COIL_W +: sps_pkg::COIL_W];
    phase_idx = phase_idx + 1'b1;
    return pat;
  endfunction

  // one step tick: updates position and phase, returns coils and position
  function automatic tick_result_t step_motor(input logic [sps_pkg::SAMPLE_W-1:0] sample);
    tick_result_t r;
    int unsigned  target;
    int unsigned  pos_now;
    r.coils = sps_pkg::COIL_OFF;
    pos_now = shaft_pos;
    if (mode.drive_off) begin
      r.coils = sps_pkg::COIL_OFF;
    end else if (mode.follower_mode) begin
      target = (int'(sample) * STEPS) / SAMPLE_RANGE;
      if (target > STEPS - 1) target = STEPS - 1;
      if (target > pos_now) begin
        shaft_pos = shaft_pos + 1'b1;
        r.coils   = next_coils(FWD_FULL);
      end else if (target < pos_now) begin
        shaft_pos = shaft_pos - 1'b1;
        r.coils   = next_coils(REV_FULL);
      end
    end else if (mode.forward_dir) begin
      shaft_pos = (pos_now + 1 >= STEPS) ? '0 : sps_pkg::POS_W'(pos_now + 1);
      r.coils   = next_coils(mode.full_step_mode ? FWD_FULL : FWD_WAVE);
    end else begin
      // counting down wraps from zero to the last step
      shaft_pos = (pos_now == 0 || pos_now > STEPS) ? sps_pkg::POS_W'(STEPS - 1)
                                                    : sps_pkg::POS_W'(pos_now - 1);
      r.coils   = next_coils(mode.full_step_mode ? REV_FULL : REV_WAVE);
    end
    r.pos = shaft_pos;
    return r;
  endfunction

  // watch all ports at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      mode.drive_off      = 1'b1;
      mode.follower_mode  = 1'b0;
      mode.full_step_mode = 1'b0;
      mode.forward_dir    = 1'b1;
      shaft_pos           = '0;
      phase_idx           = '0;
      expected_q.delete();
    end else begin
      // mode register writes
      if (cfg_we) begin
        case (sps_pkg::cfg_idx_t'(cfg_index))
          sps_pkg::CFG_DRIVE_OFF:      mode.drive_off      = cfg_wdata[0];
          sps_pkg::CFG_FOLLOWER_MODE:  mode.follower_mode  = cfg_wdata[0];
          sps_pkg::CFG_FULL_STEP_MODE: mode.full_step_mode = cfg_wdata[0];
          sps_pkg::CFG_FORWARD_DIR:    mode.forward_dir    = cfg_wdata[0];
          default: ;
        endcase
      end

      // accepted tick transaction
      if (in_valid && in_ready) expected_q.push_back(step_motor(in_pot_sample));

      // accepted result transaction
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result coils=%h pos=%0d with no tick pending",
                                    out_coil_pattern, out_position));
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (out_coil_pattern !== want.coils)
            report_mismatch($sformatf("result %0d coil_pattern %h, expected %h",
                                      checked, out_coil_pattern, want.coils));
          if (out_position !== want.pos)
            report_mismatch($sformatf("result %0d position %0d, expected %0d",
                                      checked, out_position, want.pos));
        end
      end

      // anything still waiting at the end never came out
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_q.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));
      end
    end
    pending = expected_q.size();
  end

endmodule

[tb/tb_stepper_phase_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_phase_sequencer
// Drives step ticks and mode writes into the stepper phase sequencer with
// random gaps and output stalls; a checker beside the block predicts every
// coil pattern and position and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_stepper_phase_sequencer;

  localparam int STEPS        = 200;
  localparam int SAMPLE_RANGE = 4096;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TICK_TARGET  = 900;

  logic                           clk           = 1'b0;
  logic                           rst_n         = 1'b0;
  logic                           in_valid      = 1'b0;
  logic [sps_pkg::SAMPLE_W-1:0]   in_pot_sample = '0;
  logic                           out_ready     = 1'b0;
  logic                           cfg_we        = 1'b0;
  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                           run_done      = 1'b0;
  logic                           rx_free       = 1'b0;

  logic                           in_ready;
  logic                           out_valid;
  logic [sps_pkg::COIL_W-1:0]     out_coil_pattern;
  logic [sps_pkg::POS_W-1:0]      out_position;

  int                    fail_count;
  int                    pending;
  int                    checked;

  int                    cycles       = 0;
  int                    ticks_sent   = 0;
  int                    mode_writes  = 0;
  int                    rx_hold      = 0;
  int                    rx_roll;
  int                    follow_base  = 0;
  bit                    steady       = 1'b0;

  stepper_phase_sequencer #(
    .STEPS        (STEPS),
    .SAMPLE_RANGE (SAMPLE_RANGE)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pot_sample    (in_pot_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coil_pattern (out_coil_pattern),
    .out_position     (out_position),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  sps_checker #(
    .STEPS        (STEPS),
    .SAMPLE_RANGE (SAMPLE_RANGE)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pot_sample    (in_pot_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coil_pattern (out_coil_pattern),
    .out_position     (out_position),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .run_done         (run_done),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, mostly short, some long
  always @(posedge clk) begin
    if (rx_free) begin
      out_ready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 60) begin
        out_ready <= 1'b1;
        rx_hold   <= $urandom_range(0, 6);
      end else if (rx_roll < 92) begin
        out_ready <= 1'b0;
        rx_hold   <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        rx_hold   <= $urandom_range(6, 25);
      end
    end
  end

  // one tick transaction, with a random gap ahead of it
  task automatic send_tick(input logic [sps_pkg::SAMPLE_W-1:0] sample);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) gap = 0;
    else if (roll < 90)      gap = $urandom_range(1, 3);
    else                     gap = $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pot_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // stop sending and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // write all four mode registers, one per cycle
  task automatic set_mode(input bit off, input bit follow, input bit full, input bit fwd);
    sps_pkg::cfg_idx_t idx[4];
    bit                val[4];
    idx = '{sps_pkg::CFG_DRIVE_OFF, sps_pkg::CFG_FOLLOWER_MODE,
            sps_pkg::CFG_FULL_STEP_MODE, sps_pkg::CFG_FORWARD_DIR};
    val = '{off, follow, full, fwd};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    mode_writes++;
  endtask

  // stimulus and verdict
  initial begin
    int         phase_len;
    int         roll;
    int         s;
    bit         off;
    bit         follow;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // motor off after reset: coils zero, position held
    send_tick(12'h000);
    send_tick(12'hFFF);

    // full-step reverse from zero wraps to the last step
    wait_idle();
    set_mode(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(12'hAAA);
    send_tick(12'h555);
    send_tick(12'h000);

    // wave forward across the top wraps to zero
    wait_idle();
    set_mode(1'b0, 1'b0, 1'b0, 1'b1);
    send_tick(12'h123);
    send_tick(12'hEDC);
    send_tick(12'h800);

    // full-step forward
    wait_idle();
    set_mode(1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(12'h7FF);
    send_tick(12'h001);

    // wave reverse down through zero
    wait_idle();
    set_mode(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(12'hFFE);
    send_tick(12'h0F0);
    send_tick(12'hF0F);

    // follower: at target, below target, step boundaries
    wait_idle();
    set_mode(1'b0, 1'b1, 1'b0, 1'b1);
    send_tick(12'hFFF);
    send_tick(12'h000);
    send_tick(12'd4075);
    send_tick(12'd21);

    // motor off in follower mode freezes everything
    wait_idle();
    set_mode(1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(12'hFFF);
    send_tick(12'h000);

    // random phases: each one a new mode setting and a burst of ticks
    while (ticks_sent < TICK_TARGET) begin
      wait_idle();
      roll   = $urandom_range(0, 99);
      off    = (roll < 12);
      follow = (roll >= 12 && roll < 55);
      steady = ($urandom_range(0, 4) == 0);
      rx_free <= steady;
      set_mode(off, follow, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

      // follower target drifts so the position catches up and settles
      s = follow_base + $urandom_range(0, 1200) - 600;
      follow_base = (s < 0) ? 0 : (s > 4095) ? 4095 : s;

      phase_len = $urandom_range(8, 60);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (!follow || roll < 15) s = $urandom_range(0, 4095);
        else if (roll < 25)       s = $urandom_range(0, 1) ? 4095 : 0;
        else                      s = follow_base + $urandom_range(0, 60) - 30;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        send_tick(sps_pkg::SAMPLE_W'(s));
      end
    end

    wait_idle();
    rx_free  <= 1'b0;
    run_done <= 1'b1;
    repeat (3) @(posedge clk);

    $display("covered %0d step ticks over %0d mode settings, %0d results compared",
             ticks_sent, mode_writes, checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
